/* design/mmss_pkg.sv */
// ----------------------------------------------------------------------------
// mmss_pkg
// Shared types, constants and the segment table for the display framer.
// ----------------------------------------------------------------------------
package mmss_pkg;

    // Slot chain length: one time frame is the longest frame
    localparam int NUM_CELLS   = 47;
    localparam int INIT_SLOTS  = 22;
    localparam int BYTE_SLOTS  = 9;
    localparam int TIME_BYTES  = 5;

    // Largest count shown (99:59)
    localparam logic [12:0] SECONDS_MAX = 13'd5999;

    // Reciprocal of 60 in 19 fractional bits, rounded up
    localparam logic [13:0] RECIP_60    = 14'd8739;

    // Fixed command bytes
    localparam logic [7:0] CMD_DATA    = 8'h40;
    localparam logic [7:0] CMD_DISPLAY = 8'h8F;
    localparam logic [7:0] CMD_ADDRESS = 8'hC0;
    localparam logic [7:0] COLON_BIT   = 8'h80;

    // Item request codes
    localparam logic FUNC_INIT = 1'b0;
    localparam logic FUNC_TIME = 1'b1;

    typedef enum logic [1:0] {
        SLOT_START = 2'd0,
        SLOT_BIT   = 2'd1,
        SLOT_STOP  = 2'd2
    } slot_kind_t;

    // One bus slot as held in a cell
    typedef struct packed {
        logic       vld;
        slot_kind_t kind;
        logic       bit_value;
        logic       last;
    } slot_t;

    // Decimal digits of one time item
    typedef struct packed {
        logic       func;
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
    } digits_t;

    // Map a decimal digit to its seven-segment pattern
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h74;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h6F;
            4'd7:    code = 8'h38;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7D;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

/* design/mmss_slot_cell.sv */
// ----------------------------------------------------------------------------
// mmss_slot_cell
// One cell of the slot chain: loads a slot in parallel or takes its neighbor's.
// ----------------------------------------------------------------------------
module mmss_slot_cell
    import mmss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  shift,
    input  slot_t load_slot,
    input  slot_t next_slot,
    output slot_t slot
);

    slot_t slot_reg;
    slot_t slot_next;

    // Select parallel load, neighbor hand-off or hold
    always_comb
    begin
        slot_next = slot_reg;
        if (load)
        begin
            slot_next = load_slot;
        end
        else if (shift)
        begin
            slot_next = next_slot;
        end
    end

    // Hold the slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

/* design/mmss_digit_split.sv */
// ----------------------------------------------------------------------------
// mmss_digit_split
// Three-stage elastic pipeline that saturates seconds and splits them into
// units and tens of seconds and of minutes.
// ----------------------------------------------------------------------------
module mmss_digit_split
    import mmss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        func,
    input  logic [12:0] seconds,
    output logic        dig_valid,
    input  logic        dig_take,
    output digits_t     digits
);

    // Stage valid flags
    logic        s1_vld_reg, s1_vld_next;
    logic        s2_vld_reg, s2_vld_next;
    logic        s3_vld_reg, s3_vld_next;
    logic        s1_adv, s2_adv, s3_adv;

    // Stage payloads
    logic        s1_func_reg;
    logic [12:0] s1_secs_reg;
    logic [6:0]  s1_mins_reg;
    logic        s2_func_reg;
    logic [5:0]  s2_s60_reg;
    logic [6:0]  s2_mins_reg;
    logic [3:0]  s2_d3_reg;
    digits_t     s3_dig_reg;

    // Datapath signals
    logic [12:0] secs_sat;
    logic [26:0] mins_prod;
    logic [12:0] mins_x60;
    logic [12:0] s60_full;
    logic [14:0] d3_prod;
    logic [9:0]  d1_prod;
    logic [3:0]  d1;
    logic [5:0]  d0_full;
    logic [6:0]  d2_full;

    // Stage handshakes: a stage moves on when the next one is free or moving
    assign s3_adv      = s3_vld_reg && dig_take;
    assign s2_adv      = s2_vld_reg && (!s3_vld_reg || s3_adv);
    assign s1_adv      = s1_vld_reg && (!s2_vld_reg || s2_adv);
    assign item_stall  = s1_vld_reg && !s1_adv;

    always_comb
    begin
        s1_vld_next = (s1_vld_reg && !s1_adv) || (item_valid && !item_stall);
        s2_vld_next = (s2_vld_reg && !s2_adv) || s1_adv;
        s3_vld_next = (s3_vld_reg && !s3_adv) || s2_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
        end
    end

    // Saturate and divide by 60 through the reciprocal
    always_comb
    begin
        secs_sat  = (seconds > SECONDS_MAX) ? SECONDS_MAX : seconds;
        mins_prod = 27'(secs_sat) * 27'(RECIP_60);
    end

    // Remainder of 60 and tens of minutes
    always_comb
    begin
        mins_x60 = {s1_mins_reg, 6'd0} - 13'({s1_mins_reg, 2'd0});
        s60_full = s1_secs_reg - mins_x60;
        d3_prod  = 15'(s1_mins_reg) * 15'd205;
    end

    // Tens and units of seconds, units of minutes
    always_comb
    begin
        d1_prod = 10'(s2_s60_reg) * 10'd13;
        d1      = {1'b0, d1_prod[9:7]};
        d0_full = s2_s60_reg - 6'({d1, 1'b0} + {d1, 3'b0});
        d2_full = s2_mins_reg - 7'({s2_d3_reg, 1'b0} + {s2_d3_reg, 3'b0});
    end

    // Advance payloads
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_func_reg <= func;
            s1_secs_reg <= secs_sat;
            s1_mins_reg <= mins_prod[25:19];
        end
        if (s1_adv)
        begin
            s2_func_reg <= s1_func_reg;
            s2_s60_reg  <= s60_full[5:0];
            s2_mins_reg <= s1_mins_reg;
            s2_d3_reg   <= d3_prod[14:11];
        end
        if (s2_adv)
        begin
            s3_dig_reg.func <= s2_func_reg;
            s3_dig_reg.d0   <= d0_full[3:0];
            s3_dig_reg.d1   <= d1;
            s3_dig_reg.d2   <= d2_full[3:0];
            s3_dig_reg.d3   <= s2_d3_reg;
        end
    end

    assign dig_valid = s3_vld_reg;
    assign digits    = s3_dig_reg;

endmodule

/* design/mmss_display_serial_framer.sv */
// ----------------------------------------------------------------------------
// mmss_display_serial_framer
// Builds the two-wire bus slot stream for a four-digit seven-segment display.
// ----------------------------------------------------------------------------
// Each item asks for the init sequence (22 slots) or a time frame (47 slots),
// and the block hands out one slot per cycle while slot_stall is low. A
// 47-cell slot chain holds the longest frame: a whole frame is loaded into
// the chain at once and shifted out one cell a cycle, unless slot_stall
// holds it, and the next frame loads in the cycle the last slot of the
// previous one leaves, so there is no gap between frames. The digit split
// ahead of the chain has three register stages, s1, s2 and s3, and an item
// passes through them in order before it is loaded into the chain; items are
// accepted while an earlier frame is still going out.
// ----------------------------------------------------------------------------
module mmss_display_serial_framer
    import mmss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        func,
    input  logic [12:0] seconds,
    output logic        slot_valid,
    input  logic        slot_stall,
    output logic [1:0]  slot_kind,
    output logic        bit_value,
    output logic        last
);

    logic    dig_valid;
    logic    load;
    logic    shift;
    digits_t digits;
    logic [7:0] frame_byte [TIME_BYTES];
    slot_t   load_slot [NUM_CELLS];
    slot_t   cell_slot [NUM_CELLS];
    slot_t   next_slot [NUM_CELLS];

    // Front end: saturate and split into decimal digits
    mmss_digit_split u_split
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .seconds    (seconds),
        .dig_valid  (dig_valid),
        .dig_take   (load),
        .digits     (digits)
    );

    // Shift whenever the head slot is taken; load once the chain drains
    assign shift = !slot_stall;
    assign load  = dig_valid && !cell_slot[1].vld && (!cell_slot[0].vld || !slot_stall);

    // Assemble the frame bytes of a time item
    always_comb
    begin
        frame_byte[0] = CMD_ADDRESS;
        frame_byte[1] = seg_code(digits.d0);
        frame_byte[2] = seg_code(digits.d1) | COLON_BIT;
        frame_byte[3] = seg_code(digits.d2);
        frame_byte[4] = seg_code(digits.d3);
    end

    // Lay out the whole frame across the cells
    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            load_slot[i] = '0;
        end
        if (digits.func == FUNC_TIME)
        begin
            load_slot[0] = '{vld: 1'b1, kind: SLOT_START, bit_value: 1'b0, last: 1'b0};
            for (int b = 0; b < TIME_BYTES; b++)
            begin
                for (int k = 0; k < BYTE_SLOTS; k++)
                begin
                    load_slot[1 + BYTE_SLOTS * b + k].vld       = 1'b1;
                    load_slot[1 + BYTE_SLOTS * b + k].kind      = SLOT_BIT;
                    load_slot[1 + BYTE_SLOTS * b + k].bit_value =
                        (k < 8) ? frame_byte[b][k[2:0]] : 1'b0;
                end
            end
            load_slot[NUM_CELLS - 1] =
                '{vld: 1'b1, kind: SLOT_STOP, bit_value: 1'b0, last: 1'b1};
        end
        else
        begin
            load_slot[0]  = '{vld: 1'b1, kind: SLOT_START, bit_value: 1'b0, last: 1'b0};
            load_slot[10] = '{vld: 1'b1, kind: SLOT_STOP, bit_value: 1'b0, last: 1'b0};
            load_slot[11] = '{vld: 1'b1, kind: SLOT_START, bit_value: 1'b0, last: 1'b0};
            load_slot[INIT_SLOTS - 1] =
                '{vld: 1'b1, kind: SLOT_STOP, bit_value: 1'b0, last: 1'b1};
            for (int k = 0; k < BYTE_SLOTS; k++)
            begin
                load_slot[1 + k].vld        = 1'b1;
                load_slot[1 + k].kind       = SLOT_BIT;
                load_slot[1 + k].bit_value  = (k < 8) ? CMD_DATA[k[2:0]] : 1'b0;
                load_slot[12 + k].vld       = 1'b1;
                load_slot[12 + k].kind      = SLOT_BIT;
                load_slot[12 + k].bit_value = (k < 8) ? CMD_DISPLAY[k[2:0]] : 1'b0;
            end
        end
    end

    // Slot chain: cell 0 drives the output, each cell takes its upper neighbor
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        if (g == NUM_CELLS - 1)
        begin : g_tail
            assign next_slot[g] = '0;
        end
        else
        begin : g_body
            assign next_slot[g] = cell_slot[g + 1];
        end

        mmss_slot_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (load),
            .shift     (shift),
            .load_slot (load_slot[g]),
            .next_slot (next_slot[g]),
            .slot      (cell_slot[g])
        );
    end

    // Drive the output from the head cell
    assign slot_valid = cell_slot[0].vld;
    assign slot_kind  = cell_slot[0].kind;
    assign bit_value  = cell_slot[0].bit_value;
    assign last       = cell_slot[0].last;

endmodule
